// File: hw/rtl/pfa_pkg.sv
// Shared types, constants and codes of the page frame allocator.
package pfa_pkg;

	localparam int unsigned FRAMES = 64;
	localparam int unsigned FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned OP_W = 2;
	localparam int unsigned OWNER_W = 8;
	localparam int unsigned PAGE_W = 7;
	localparam int unsigned BYTES_W = 15;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PSEL_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 7;

	localparam int unsigned USABLE_RESET = 64;
	localparam int unsigned ACTIVE_RESET = (FRAMES < USABLE_RESET) ? FRAMES : USABLE_RESET;

	// Page sizes are the base, twice the base and four times the base.
	localparam int unsigned PAGE_BYTES_BASE = 100;
	localparam int unsigned SUM_W = BYTES_W + 1;
	localparam int unsigned MUL_W = 16;
	localparam int unsigned PROD_W = SUM_W + MUL_W;
	localparam int unsigned RECIP_SHIFT = 22;
	localparam int unsigned Q_W = PROD_W - RECIP_SHIFT;
	localparam int unsigned NEED_W = Q_W + 1;
	localparam logic [MUL_W-1:0] RECIP_MUL =
		MUL_W'(((64'd1 << RECIP_SHIFT) + PAGE_BYTES_BASE - 1) / PAGE_BYTES_BASE);

	localparam logic [PSEL_W-1:0] PSEL_BASE = 2'd0;
	localparam logic [PSEL_W-1:0] PSEL_DOUBLE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USABLE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_RELEASE = 2'd1,
		OP_READ = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRODUCT,
		S_DECIDE,
		S_SCAN,
		S_RESPOND
	} state_t;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [PAGE_W-1:0] page;
	} pfa_entry_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [OWNER_W-1:0] owner_id;
		logic [BYTES_W-1:0] request_bytes;
		logic [FRAME_W-1:0] frame_index;
	} pfa_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0] pages_affected;
		logic [CNT_W-1:0] free_frames;
		logic [OWNER_W-1:0] entry_owner;
		logic [PAGE_W-1:0] entry_page;
	} pfa_result_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic decide;
		logic scan_issue;
		logic lookup;
		logic respond;
	} pfa_cmd_t;

	typedef struct packed {
		op_t op;
		logic owner_zero;
		logic need_zero;
		logic no_fit;
		logic scan_end;
		logic out_free;
	} pfa_sts_t;

endpackage

// File: hw/rtl/pfa_req_if.sv
// Request channel of the page frame allocator.
interface pfa_req_if;
	import pfa_pkg::*;

	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic [OWNER_W-1:0] owner_id;
	logic [BYTES_W-1:0] request_bytes;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, op, owner_id, request_bytes, frame_index, input ready);
	modport sink (input valid, op, owner_id, request_bytes, frame_index, output ready);
endinterface

// File: hw/rtl/pfa_rsp_if.sv
// Response channel of the page frame allocator.
interface pfa_rsp_if;
	import pfa_pkg::*;

	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0] pages_affected;
	logic [CNT_W-1:0] free_frames;
	logic [OWNER_W-1:0] entry_owner;
	logic [PAGE_W-1:0] entry_page;

	modport source (output valid, status, pages_affected, free_frames, entry_owner, entry_page,
		input ready);
	modport sink (input valid, status, pages_affected, free_frames, entry_owner, entry_page,
		output ready);
endinterface

// File: hw/rtl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// File: hw/rtl/pfa_ctrl.sv
// Controller state machine of the page frame allocator.
module pfa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input pfa_pkg::pfa_sts_t sts,
	output pfa_pkg::pfa_cmd_t cmd
);
	import pfa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_PRODUCT;
				end
			end
			S_PRODUCT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (sts.op)
					OP_ALLOC: begin
						if (sts.owner_zero || sts.need_zero || sts.no_fit) begin
							state_d = S_RESPOND;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_RELEASE: begin
						if (sts.owner_zero) begin
							state_d = S_RESPOND;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						state_d = S_RESPOND;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_RESPOND;
				end
			end
			S_RESPOND: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			S_PRODUCT: begin
				cmd.mul = 1'b1;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.lookup = (sts.op == OP_READ);
			end
			S_SCAN: begin
				cmd.scan_issue = !sts.scan_end;
			end
			S_RESPOND: begin
				cmd.respond = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

// File: hw/rtl/pfa_dp.sv
// Datapath of the page frame allocator: registers, page count, frame table scan.
module pfa_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input pfa_pkg::pfa_item_t item,
	input pfa_pkg::pfa_cmd_t cmd,
	output pfa_pkg::pfa_sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output pfa_pkg::pfa_result_t out_data
);
	import pfa_pkg::*;

	localparam int unsigned WIDTH_ENTRY = $bits(pfa_entry_t);

	logic [PSEL_W-1:0] page_sel_q;
	logic [CNT_W-1:0] usable_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] pages_q;
	logic [CNT_W-1:0] ptr_q;
	logic [FRAMES-1:0] valid_q;
	logic nofit_q;
	logic out_valid_q;
	pfa_result_t out_q;

	op_t op_q;
	logic [OWNER_W-1:0] owner_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [FRAME_W-1:0] index_q;
	logic [PROD_W-1:0] prod_q;

	logic scan_s1;
	logic [FRAME_W-1:0] addr_s1;
	logic hit_valid_s1;

	logic [CNT_W-1:0] active;
	logic [CNT_W-1:0] cfg_active;
	logic [SUM_W-1:0] bytes_sum;
	logic [Q_W-1:0] quot_base;
	logic [NEED_W-1:0] need;
	logic no_fit;
	logic in_range;

	logic rd_en;
	logic [FRAME_W-1:0] rd_addr;
	pfa_entry_t rd_entry;
	logic [WIDTH_ENTRY-1:0] rd_raw;
	logic [OWNER_W-1:0] cur_owner;
	logic alloc_hit;
	logic rel_hit;
	pfa_entry_t wr_entry;

	assign active = (usable_q > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : usable_q;

	always_comb begin
		cfg_active = active;
		if (cfg_index == CFG_USABLE) begin
			cfg_active = (cfg_wdata > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : cfg_wdata;
		end
	end

	// Round up to base pages, then to the selected page size.
	assign bytes_sum = SUM_W'(bytes_q) + SUM_W'(PAGE_BYTES_BASE - 1);
	assign quot_base = prod_q[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		priority if (page_sel_q == PSEL_BASE) begin
			need = NEED_W'(quot_base);
		end else if (page_sel_q == PSEL_DOUBLE) begin
			need = (NEED_W'(quot_base) + NEED_W'(1)) >> 1;
		end else begin
			need = (NEED_W'(quot_base) + NEED_W'(3)) >> 2;
		end
	end

	assign no_fit = need > NEED_W'(free_q);
	assign in_range = {1'b0, index_q} < active;

	assign sts.op = op_q;
	assign sts.owner_zero = (owner_q == '0);
	assign sts.need_zero = (need == '0);
	assign sts.no_fit = no_fit;
	assign sts.scan_end = (ptr_q == active);
	assign sts.out_free = !out_valid_q || out_ready;

	assign rd_en = cmd.scan_issue || cmd.lookup;
	assign rd_addr = cmd.lookup ? index_q : ptr_q[FRAME_W-1:0];

	pfa_ram #(
		.WIDTH(WIDTH_ENTRY),
		.DEPTH(FRAMES)
	) u_table (
		.clk(clk),
		.wr_en(alloc_hit),
		.wr_addr(addr_s1),
		.wr_data(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_entry = pfa_entry_t'(rd_raw);
	assign cur_owner = hit_valid_s1 ? rd_entry.owner : '0;
	assign alloc_hit = scan_s1 && (op_q == OP_ALLOC) && (cur_owner == '0)
		&& (NEED_W'(pages_q) < need);
	assign rel_hit = scan_s1 && (op_q == OP_RELEASE) && (cur_owner == owner_q);
	assign wr_entry.owner = owner_q;
	assign wr_entry.page = pages_q + PAGE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_sel_q <= PSEL_BASE;
			usable_q <= CNT_W'(USABLE_RESET);
			free_q <= CNT_W'(ACTIVE_RESET);
			valid_q <= '0;
			pages_q <= '0;
			ptr_q <= '0;
			nofit_q <= 1'b0;
			scan_s1 <= 1'b0;
			hit_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_issue;
			if (rd_en) begin
				hit_valid_s1 <= valid_q[rd_addr];
			end
			if (cfg_we) begin
				if (cfg_index == CFG_USABLE) begin
					usable_q <= cfg_wdata;
				end else begin
					page_sel_q <= cfg_wdata[PSEL_W-1:0];
				end
				valid_q <= '0;
				free_q <= cfg_active;
			end else if (alloc_hit) begin
				valid_q[addr_s1] <= 1'b1;
				free_q <= free_q - CNT_W'(1);
			end else if (rel_hit) begin
				valid_q[addr_s1] <= 1'b0;
				free_q <= free_q + CNT_W'(1);
			end
			if (cmd.capture) begin
				pages_q <= '0;
			end else if (alloc_hit || rel_hit) begin
				pages_q <= pages_q + CNT_W'(1);
			end
			if (cmd.capture) begin
				ptr_q <= '0;
			end else if (cmd.scan_issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.decide) begin
				nofit_q <= (op_q == OP_ALLOC) && (owner_q != '0) && (need != '0) && no_fit;
			end
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op_t'(item.op);
			owner_q <= item.owner_id;
			bytes_q <= item.request_bytes;
			index_q <= item.frame_index;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(bytes_sum) * PROD_W'(RECIP_MUL);
		end
		if (cmd.scan_issue) begin
			addr_s1 <= ptr_q[FRAME_W-1:0];
		end
		if (cmd.respond) begin
			out_q.pages_affected <= pages_q;
			out_q.free_frames <= free_q;
			out_q.entry_owner <= '0;
			out_q.entry_page <= '0;
			if (nofit_q) begin
				out_q.status <= ST_NO_FIT;
			end else if ((op_q == OP_READ) && !in_range) begin
				out_q.status <= ST_RANGE;
			end else begin
				out_q.status <= ST_DONE;
			end
			if ((op_q == OP_READ) && in_range && hit_valid_s1) begin
				out_q.entry_owner <= rd_entry.owner;
				out_q.entry_page <= rd_entry.page;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

// File: hw/rtl/page_frame_allocator_core.sv
// Page frame allocator top level: request and response channels, configuration port.
// An allocate or release that walks the frame table reads one frame per cycle through
// its single read port; a read, a refused or empty allocate, a release for owner zero
// or any other op does not walk the table. A stalled response holds the allocator in
// its respond state until the output register is free. A result waits in the output
// register while the next request is taken. Writing either configuration register
// frees every frame at once and sets the free count to the usable frame count, capped
// at 64; page select codes two and three act as 400-byte pages.
module page_frame_allocator_core (
	input logic clk,
	input logic arst_n,
	pfa_req_if.sink req,
	pfa_rsp_if.source rsp,
	input logic cfg_we,
	input logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pfa_pkg::*;

	pfa_cmd_t cmd;
	pfa_sts_t sts;
	pfa_item_t item;
	pfa_result_t result;

	assign item.op = req.op;
	assign item.owner_id = req.owner_id;
	assign item.request_bytes = req.request_bytes;
	assign item.frame_index = req.frame_index;

	pfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts(sts),
		.cmd(cmd)
	);

	pfa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_data(result)
	);

	assign rsp.status = result.status;
	assign rsp.pages_affected = result.pages_affected;
	assign rsp.free_frames = result.free_frames;
	assign rsp.entry_owner = result.entry_owner;
	assign rsp.entry_page = result.entry_page;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an item is in work");

	a_refusal_no_pages: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_NO_FIT) |-> (rsp.pages_affected == '0))
		else $error("refused allocation reports pages");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.free_frames <= CNT_W'(FRAMES)))
		else $error("free frame count beyond table size");

	a_range_empty_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_RANGE) |->
		(rsp.entry_owner == '0 && rsp.entry_page == '0))
		else $error("out of range read returns entry data");

	a_scan_no_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> (!cmd.lookup && !cmd.respond && !req.ready))
		else $error("table scan overlaps lookup or response");
endmodule
